/* rtl/core/fti_pkg.sv */
// fti_pkg: shared types and constants for the float to int rounding unit
// no dependencies
package fti_pkg;

    localparam logic FUNC_F64 = 1'b0;
    localparam logic FUNC_F32 = 1'b1;

    // special result classes decided in the decode stage
    localparam logic [1:0] CLS_NORMAL = 2'd0;
    localparam logic [1:0] CLS_ZERO   = 2'd1;
    localparam logic [1:0] CLS_SAT    = 2'd2;

    typedef struct packed {
        logic        func;
        logic        neg;
        logic [1:0]  cls;
        logic        left;     // mantissa shifts left (no fraction bits)
        logic [5:0]  shamt;    // shift amount, left or right
        logic [52:0] mant;     // significand with hidden bit, binary32 aligned low
    } dec_t;

    typedef struct packed {
        logic        func;
        logic        neg;
        logic [1:0]  cls;
        logic [63:0] mag;
    } mag_t;

endpackage

/* rtl/core/float_to_int_round_half_up_unit.sv */
// float_to_int_round_half_up_unit: top level, three stage pipeline
// depends on fti_pkg, fti_decode, fti_shift
//
// Converts a binary64 (func 0) or binary32 in the low bits (func 1) to a
// signed integer rounded to nearest with ties toward +inf, i.e. floor(x+1/2).
// NaN gives 0, infinities and out-of-range values saturate; int32 results
// are sign-extended. One item enters per cycle while not stalled; stages
// (decode, round/shift, sign/saturate) each end in a register. A stall on
// the output freezes only the stages that are full, so bubbles collapse.
module float_to_int_round_half_up_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [63:0] value_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] rounded
);
    import fti_pkg::*;

    dec_t        dec_w;
    mag_t        mag_w;
    dec_t        s1_reg;
    mag_t        s2_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic [63:0] out_reg;
    logic [63:0] res_next;
    logic        en1, en2, en3;
    logic [63:0] maxv, minv, sgn;

    // stage enables: a stage moves when it is empty or the one after it can take it
    assign en3 = !v3_reg || !out_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    fti_decode u_dec (.func(func), .value_bits(value_bits), .dec(dec_w));
    fti_shift  u_sh  (.dec(s1_reg), .mo(mag_w));

    // sign and saturation
    always_comb
    begin
        if (s2_reg.func == FUNC_F32)
        begin
            maxv = 64'h0000_0000_7FFF_FFFF;
            minv = 64'hFFFF_FFFF_8000_0000;
        end
        else
        begin
            maxv = 64'h7FFF_FFFF_FFFF_FFFF;
            minv = 64'h8000_0000_0000_0000;
        end
        sgn = s2_reg.neg ? (64'd0 - s2_reg.mag) : s2_reg.mag;
        case (s2_reg.cls)
            CLS_ZERO: res_next = '0;
            CLS_SAT:  res_next = s2_reg.neg ? minv : maxv;
            default:
            begin
                if (s2_reg.func == FUNC_F32)
                    res_next = {{32{sgn[31]}}, sgn[31:0]};
                else
                    res_next = sgn;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) s1_reg <= dec_w;
        if (en2) s2_reg <= mag_w;
        if (en3) out_reg <= res_next;
    end

    assign out_valid = v3_reg;
    assign rounded   = out_reg;

endmodule

/* rtl/core/fti_decode.sv */
// fti_decode: field split, classification and shift amount
// depends on fti_pkg
module fti_decode (
    input  logic             func,
    input  logic [63:0]      value_bits,
    output fti_pkg::dec_t    dec
);
    import fti_pkg::*;

    logic        neg;
    logic [10:0] expf;
    logic [51:0] frac;
    logic        exp_max;
    logic [11:0] e;          // unbiased exponent + 1
    logic [11:0] mbits;
    logic [11:0] ilim;

    always_comb
    begin
        if (func == FUNC_F32)
        begin
            neg     = value_bits[31];
            expf    = {3'b0, value_bits[30:23]};
            frac    = {29'b0, value_bits[22:0]};
            exp_max = (value_bits[30:23] == 8'hFF);
            e       = {4'b0, value_bits[30:23]} - 12'd126;
            mbits   = 12'd24;
            ilim    = 12'd32;
        end
        else
        begin
            neg     = value_bits[63];
            expf    = value_bits[62:52];
            frac    = value_bits[51:0];
            exp_max = (value_bits[62:52] == 11'h7FF);
            e       = {1'b0, expf} - 12'd1022;
            mbits   = 12'd53;
            ilim    = 12'd64;
        end

        dec.func  = func;
        dec.neg   = neg;
        dec.left  = 1'b0;
        dec.shamt = '0;
        dec.mant  = (func == FUNC_F32) ? {29'b0, 1'b1, frac[22:0]} : {1'b1, frac};
        if (exp_max)
            dec.cls = (frac != '0) ? CLS_ZERO : CLS_SAT;
        else if (expf == '0 || e[11])
            dec.cls = CLS_ZERO;          // e negative means |x| < 0.5
        else if (e >= ilim)
            dec.cls = CLS_SAT;
        else
        begin
            dec.cls = CLS_NORMAL;
            if (e >= mbits)
            begin
                dec.left  = 1'b1;
                dec.shamt = 6'(e - mbits);
            end
            else
                dec.shamt = 6'(mbits - e);   // q, between 1 and mbits
        end
    end

endmodule

/* rtl/core/fti_shift.sv */
// fti_shift: rounds and aligns the significand to an integer magnitude
// depends on fti_pkg
module fti_shift (
    input  fti_pkg::dec_t dec,
    output fti_pkg::mag_t mo
);
    import fti_pkg::*;

    logic [64:0] half;
    logic [64:0] bias;
    logic [64:0] sum;

    always_comb
    begin
        half = 65'd1 << (dec.shamt - 6'd1);
        // ties up: positive adds half, negative adds half-1
        bias = dec.neg ? half - 65'd1 : half;
        sum  = {12'b0, dec.mant} + bias;
        mo.func = dec.func;
        mo.neg  = dec.neg;
        mo.cls  = dec.cls;
        if (dec.left)
            mo.mag = {11'b0, dec.mant} << dec.shamt;
        else
            mo.mag = 64'(sum >> dec.shamt);
    end

endmodule

/* rtl/core/fti_checker.sv */
// fti_checker: port-level checks for the rounding unit
// depends on float_to_int_round_half_up_unit ports only
module fti_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] rounded
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rounded))
        else $error("stalled item changed");

    a_noinstall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
        else $error("item lost in pipeline");

endmodule

bind float_to_int_round_half_up_unit fti_checker u_fti_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .rounded(rounded)
);
